// ===== src/fels_pkg.sv =====
// Package for the flash error log store: sizes, status mark bits, operation
// codes and the command/status structs between controller and datapath.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fels_pkg;

  localparam int NUM_BLOCKS      = 2;
  localparam int SLOTS_PER_BLOCK = 127;
  localparam int PAYLOAD_BITS    = 64;

  localparam int TOTAL_SLOTS = NUM_BLOCKS * SLOTS_PER_BLOCK;
  localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W       = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int SUM_W       = CNT_W + $clog2(NUM_BLOCKS) + 1;

  localparam logic [7:0]  HDR_ERASED = 8'hFF;
  localparam logic [7:0]  VER_RESET  = 8'h01;
  localparam logic [7:0]  LIVE_MAX   = 8'hFF;
  localparam logic [63:0] PAY_MASK   =
    (PAYLOAD_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << PAYLOAD_BITS) - 64'd1);

  // Active-low slot marks.
  localparam int ST_ALLOC_BIT = 2;
  localparam int ST_VALID_BIT = 1;
  localparam int ST_DEL_BIT   = 0;
  localparam logic [2:0] ST_ERASED  = 3'b111;
  localparam logic [2:0] ST_PROGRAM = 3'b001;
  localparam logic [2:0] ST_DELETE  = 3'b110;

  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  record_index;
    logic [63:0] payload;
  } in_t;

  typedef struct packed {
    logic        ready_res;
    logic        stored;
    logic        found;
    logic        payload_valid;
    logic [63:0] read_payload;
    logic [7:0]  live_count;
  } out_t;

  typedef struct packed {
    logic in_load;
    logic blk_clr;
    logic blk_inc;
    logic cnt_clr;
    logic walk_init;
    logic walk_rd;
    logic walk_clr;
    logic walk_erase;
    logic blk_erase;
    logic sel_active;
    logic st_rd;
    logic st_wr;
    logic rd_start;
    logic rd_step;
    logic rd_found;
    logic rd_issue;
    logic rd_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       walk_end;
    logic       clr_end;
    logic       blk_last;
    logic       hdr_erased;
    logic       hdr_match;
    logic       del_full;
    logic       act_full;
    logic       scanned;
    logic       rd_skip;
    logic       rd_in_range;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/fels_dp.sv =====
// Datapath of the flash error log store: slot status and payload memories,
// block headers and counters, walk counters, result and output registers.
// Depends on fels_pkg; driven by fels_ctrl through cmd_t.
`default_nettype none

module fels_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire fels_pkg::in_t  in_data,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_data,
  input  wire fels_pkg::cmd_t cmd,
  output fels_pkg::sts_t      sts,
  output fels_pkg::out_t      out_data
);
  import fels_pkg::*;

  logic [2:0]  st_mem  [TOTAL_SLOTS];
  logic [63:0] pay_mem [TOTAL_SLOTS];

  logic [7:0]       ver_r;
  logic [7:0]       hdr_r   [NUM_BLOCKS];
  logic [CNT_W-1:0] alloc_r [NUM_BLOCKS];
  logic [CNT_W-1:0] del_r   [NUM_BLOCKS];
  logic [BLK_W-1:0] act_r;
  logic             scanned_r;
  logic [BLK_W-1:0] blk_r;
  logic [CNT_W-1:0] slot_r;
  logic [ADDR_W-1:0] addr_r;
  logic             pend_r;
  logic             pend_clr_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [7:0]       dist_r;
  logic [2:0]       st_q_r;
  logic [63:0]      pay_q_r;
  in_t              in_r;
  logic             res_stored_r;
  logic             res_found_r;
  logic             res_pvalid_r;
  logic [63:0]      res_pay_r;
  out_t             out_r;

  logic             a_inc, d_inc, clr_hit;
  logic [CNT_W-1:0] n_live;
  logic [8:0]       rd_slot;
  logic [ADDR_W-1:0] rd_addr, store_addr, st_raddr, st_waddr;
  logic             st_we;
  logic [2:0]       st_wdata;
  logic [BLK_W-1:0] sel_blk;
  logic [CNT_W-1:0] best;
  logic [SUM_W-1:0] live_sum;
  logic [7:0]       live;

  function automatic logic [ADDR_W-1:0] blk_base(logic [BLK_W-1:0] b);
    return ADDR_W'(int'(b) * SLOTS_PER_BLOCK);
  endfunction

  function automatic logic [CNT_W-1:0] live_of(logic [CNT_W-1:0] a, logic [CNT_W-1:0] d);
    return (a >= d) ? a - d : '0;
  endfunction

  always_comb begin
    a_inc   = !st_q_r[ST_ALLOC_BIT] || !st_q_r[ST_DEL_BIT];
    d_inc   = !st_q_r[ST_DEL_BIT] || (!st_q_r[ST_ALLOC_BIT] && st_q_r[ST_VALID_BIT]);
    clr_hit = !st_q_r[ST_ALLOC_BIT] && st_q_r[ST_DEL_BIT];

    n_live     = live_of(alloc_r[blk_r], del_r[blk_r]);
    rd_slot    = 9'(del_r[blk_r]) + 9'(dist_r);
    rd_addr    = ADDR_W'(blk_base(blk_r) + ADDR_W'(rd_slot));
    store_addr = blk_base(act_r) + ADDR_W'(alloc_r[act_r]);

    st_raddr = cmd.st_rd ? store_addr : (cmd.rd_issue ? rd_addr : addr_r);
    st_we    = cmd.walk_erase || cmd.st_wr || (pend_r && pend_clr_r && clr_hit);
    if (cmd.walk_erase) begin
      st_waddr = addr_r;
      st_wdata = ST_ERASED;
    end else if (cmd.st_wr) begin
      st_waddr = addr_r;
      st_wdata = st_q_r & ST_PROGRAM;
    end else begin
      st_waddr = wb_addr_r;
      st_wdata = st_q_r & ST_DELETE;
    end

    // The first block is the default; a later one wins only with strictly
    // more records and room left.
    sel_blk = '0;
    best    = alloc_r[0];
    for (int b = 1; b < NUM_BLOCKS; b++) begin
      if (alloc_r[b] > best && alloc_r[b] != CNT_W'(SLOTS_PER_BLOCK)) begin
        sel_blk = BLK_W'(b);
        best    = alloc_r[b];
      end
    end

    live_sum = '0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      live_sum = live_sum + SUM_W'(live_of(alloc_r[b], del_r[b]));
    end
    live = (live_sum > SUM_W'(LIVE_MAX)) ? LIVE_MAX : live_sum[7:0];
  end

  always_comb begin
    sts.op          = in_data.operation;
    sts.walk_end    = (slot_r == CNT_W'(SLOTS_PER_BLOCK));
    sts.clr_end     = (slot_r == alloc_r[blk_r]);
    sts.blk_last    = (blk_r == BLK_W'(NUM_BLOCKS - 1));
    sts.hdr_erased  = (hdr_r[blk_r] == HDR_ERASED);
    sts.hdr_match   = (hdr_r[blk_r] == ver_r);
    sts.del_full    = (del_r[blk_r] == CNT_W'(SLOTS_PER_BLOCK));
    sts.act_full    = (alloc_r[act_r] >= CNT_W'(SLOTS_PER_BLOCK));
    sts.scanned     = scanned_r;
    sts.rd_skip     = (9'(n_live) <= 9'(dist_r));
    sts.rd_in_range = (rd_slot < 9'(SLOTS_PER_BLOCK));
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_q_r <= st_mem[st_raddr];
    if (cmd.st_wr) begin
      pay_mem[addr_r] <= in_r.payload & PAY_MASK;
    end
    pay_q_r <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= addr_r;
    if (cmd.in_load) begin
      in_r         <= in_data;
      res_stored_r <= 1'b0;
      res_found_r  <= 1'b0;
      res_pvalid_r <= 1'b0;
      res_pay_r    <= '0;
    end
    if (cmd.st_wr) begin
      res_stored_r <= 1'b1;
    end
    if (cmd.rd_found) begin
      res_found_r <= 1'b1;
    end
    if (cmd.rd_fin) begin
      if (!st_q_r[ST_VALID_BIT] && st_q_r[ST_DEL_BIT]) begin
        res_pvalid_r <= 1'b1;
        res_pay_r    <= pay_q_r & PAY_MASK;
      end
    end
    if (cmd.out_load) begin
      out_r.ready_res     <= scanned_r;
      out_r.stored        <= res_stored_r;
      out_r.found         <= res_found_r;
      out_r.payload_valid <= res_pvalid_r;
      out_r.read_payload  <= res_pay_r;
      out_r.live_count    <= live;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r      <= VER_RESET;
      act_r      <= '0;
      scanned_r  <= 1'b0;
      blk_r      <= '0;
      slot_r     <= '0;
      addr_r     <= '0;
      pend_r     <= 1'b0;
      pend_clr_r <= 1'b0;
      dist_r     <= '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        hdr_r[b]   <= HDR_ERASED;
        alloc_r[b] <= '0;
        del_r[b]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        ver_r <= cfg_data;
      end
      pend_r     <= cmd.walk_rd;
      pend_clr_r <= cmd.walk_clr;

      if (cmd.blk_clr) begin
        blk_r <= '0;
      end else if (cmd.blk_inc) begin
        blk_r <= blk_r + 1'b1;
      end

      if (cmd.walk_init) begin
        slot_r <= '0;
        addr_r <= blk_base(blk_r);
      end else if (cmd.walk_rd || cmd.walk_erase) begin
        slot_r <= slot_r + 1'b1;
        addr_r <= addr_r + 1'b1;
      end else if (cmd.st_rd) begin
        addr_r <= store_addr;
      end

      // A status word read in the cycle before is folded into the counts of
      // the block being walked.
      if (pend_r && !pend_clr_r) begin
        alloc_r[blk_r] <= alloc_r[blk_r] + CNT_W'(a_inc);
        del_r[blk_r]   <= del_r[blk_r] + CNT_W'(d_inc);
      end
      if (pend_r && pend_clr_r && clr_hit) begin
        del_r[blk_r] <= del_r[blk_r] + 1'b1;
      end
      if (cmd.cnt_clr || cmd.blk_erase) begin
        alloc_r[blk_r] <= '0;
        del_r[blk_r]   <= '0;
      end
      if (cmd.blk_erase) begin
        hdr_r[blk_r] <= HDR_ERASED;
      end

      if (cmd.st_wr) begin
        alloc_r[act_r] <= alloc_r[act_r] + 1'b1;
        if (alloc_r[act_r] == '0 && hdr_r[act_r] == HDR_ERASED) begin
          hdr_r[act_r] <= ver_r;
        end
      end
      if (cmd.sel_active) begin
        act_r     <= sel_blk;
        scanned_r <= 1'b1;
      end

      if (cmd.rd_start) begin
        dist_r <= in_data.record_index;
      end else if (cmd.rd_step) begin
        dist_r <= dist_r - 8'(n_live);
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== src/fels_ctrl.sv =====
// Controller of the flash error log store: one-hot state machine that
// sequences the reset sweep, scan, store, clear and read operations.
// Depends on fels_pkg; drives fels_dp through cmd_t and reads sts_t.
`default_nettype none

module fels_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire fels_pkg::sts_t sts,
  output fels_pkg::cmd_t      cmd
);
  import fels_pkg::*;

  typedef enum logic [14:0] {
    S_INIT_START = 15'b000000000000001,
    S_INIT_WALK  = 15'b000000000000010,
    S_IDLE       = 15'b000000000000100,
    S_SC_BLK     = 15'b000000000001000,
    S_SC_WALK    = 15'b000000000010000,
    S_SC_CHK     = 15'b000000000100000,
    S_ER_WALK    = 15'b000000001000000,
    S_SC_SEL     = 15'b000000010000000,
    S_ST_CHK     = 15'b000000100000000,
    S_ST_WR      = 15'b000001000000000,
    S_CL_START   = 15'b000010000000000,
    S_CL_WALK    = 15'b000100000000000,
    S_RD_STEP    = 15'b001000000000000,
    S_RD_DATA    = 15'b010000000000000,
    S_DONE       = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   store_r, store_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    store_nxt     = store_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_INIT_START: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_INIT_WALK;
      end
      S_INIT_WALK: begin
        if (!sts.walk_end) begin
          cmd.walk_erase = 1'b1;
        end else if (sts.blk_last) begin
          cmd.blk_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.blk_inc = 1'b1;
          state_nxt   = S_INIT_START;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          store_nxt   = 1'b0;
          if (sts.op == OP_SCAN) begin
            cmd.blk_clr = 1'b1;
            state_nxt   = S_SC_BLK;
          end else if (!sts.scanned) begin
            state_nxt = S_DONE;
          end else if (sts.op == OP_STORE) begin
            state_nxt = S_ST_CHK;
          end else if (sts.op == OP_CLEAR) begin
            cmd.blk_clr = 1'b1;
            state_nxt   = S_CL_START;
          end else begin
            cmd.blk_clr  = 1'b1;
            cmd.rd_start = 1'b1;
            state_nxt    = S_RD_STEP;
          end
        end
      end
      S_SC_BLK: begin
        cmd.cnt_clr = 1'b1;
        if (sts.hdr_erased) begin
          if (sts.blk_last) begin
            state_nxt = S_SC_SEL;
          end else begin
            cmd.blk_inc = 1'b1;
          end
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = sts.hdr_match ? S_SC_WALK : S_ER_WALK;
        end
      end
      S_SC_WALK: begin
        if (!sts.walk_end) begin
          cmd.walk_rd = 1'b1;
        end else begin
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (sts.del_full) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_ER_WALK;
        end else if (sts.blk_last) begin
          state_nxt = S_SC_SEL;
        end else begin
          cmd.blk_inc = 1'b1;
          state_nxt   = S_SC_BLK;
        end
      end
      S_ER_WALK: begin
        if (!sts.walk_end) begin
          cmd.walk_erase = 1'b1;
        end else begin
          cmd.blk_erase = 1'b1;
          if (sts.blk_last) begin
            state_nxt = S_SC_SEL;
          end else begin
            cmd.blk_inc = 1'b1;
            state_nxt   = S_SC_BLK;
          end
        end
      end
      S_SC_SEL: begin
        cmd.sel_active = 1'b1;
        state_nxt      = store_r ? S_ST_CHK : S_DONE;
      end
      S_ST_CHK: begin
        // A full active block gets one rescan before the store gives up.
        if (sts.act_full) begin
          if (store_r) begin
            state_nxt = S_DONE;
          end else begin
            store_nxt   = 1'b1;
            cmd.blk_clr = 1'b1;
            state_nxt   = S_SC_BLK;
          end
        end else begin
          cmd.st_rd = 1'b1;
          state_nxt = S_ST_WR;
        end
      end
      S_ST_WR: begin
        cmd.st_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_CL_START: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_CL_WALK;
      end
      S_CL_WALK: begin
        if (!sts.clr_end) begin
          cmd.walk_rd  = 1'b1;
          cmd.walk_clr = 1'b1;
        end else if (sts.blk_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.blk_inc = 1'b1;
          state_nxt   = S_CL_START;
        end
      end
      S_RD_STEP: begin
        if (sts.rd_skip) begin
          if (sts.blk_last) begin
            state_nxt = S_DONE;
          end else begin
            cmd.rd_step = 1'b1;
            cmd.blk_inc = 1'b1;
          end
        end else begin
          cmd.rd_found = 1'b1;
          if (sts.rd_in_range) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_RD_DATA;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD_DATA: begin
        cmd.rd_fin = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT_START;
      store_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      store_r     <= store_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/flash_error_log_store.sv =====
// Top level of the flash error log store: controller plus datapath.
// Depends on fels_pkg, fels_ctrl and fels_dp.
//
//   channel  direction  handshake       payload
//   in_      input      valid / stall   fels_pkg::in_t
//   out_     output     valid / stall   fels_pkg::out_t
//   cfg_     input      valid / ready   header version, 8 bits
//
// One transaction at a time. Scan walks each programmed block, one slot per
// cycle through the status memory read port; a block whose slots are all
// deleted, or whose header does not match the version, is erased by a walk
// of its own. Clear walks the allocated slots of each block. A store takes
// a scan more when the active block is full. After reset the status memory
// is swept with in_stall high. A finished result waits in the output
// register while the next transaction is accepted.
`default_nettype none

module flash_error_log_store (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fels_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fels_pkg::out_t     out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_data
);
  import fels_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fels_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fels_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== src/fels_checker.sv =====
// Port-level checker for the flash error log store, bound to the top level.
// Depends on fels_pkg and flash_error_log_store.
`default_nettype none

module fels_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire fels_pkg::out_t out_data
);
  import fels_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  a_store_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ready_res || !out_data.stored))
    else $error("store reported before any scan");

  a_read_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.found || !out_data.payload_valid) &&
                  (out_data.payload_valid || out_data.read_payload == '0))
    else $error("read flags and payload disagree");

  a_empty_before_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ready_res |-> out_data.live_count == '0)
    else $error("live records reported before any scan");

endmodule

bind flash_error_log_store fels_checker u_fels_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
